@@ design/rlp_pkg.sv @@
// Shared types and constants for the ARM ELF relocation patcher.
// Used by rlp_decode, rlp_sum, rlp_pack and arm_elf_relocation_patcher.
package rlp_pkg;

  // ARM ELF relocation type numbers
  localparam logic [7:0] R_NONE        = 8'd0;
  localparam logic [7:0] R_PC24        = 8'd1;
  localparam logic [7:0] R_ABS32       = 8'd2;
  localparam logic [7:0] R_THM_CALL    = 8'd10;
  localparam logic [7:0] R_PLT32       = 8'd27;
  localparam logic [7:0] R_CALL        = 8'd28;
  localparam logic [7:0] R_JUMP24      = 8'd29;
  localparam logic [7:0] R_THM_JUMP24  = 8'd30;
  localparam logic [7:0] R_V4BX        = 8'd40;
  localparam logic [7:0] R_PREL31      = 8'd42;
  localparam logic [7:0] R_MOVW        = 8'd43;
  localparam logic [7:0] R_MOVT        = 8'd44;
  localparam logic [7:0] R_THM_MOVW    = 8'd47;
  localparam logic [7:0] R_THM_MOVT    = 8'd48;

  // internal operation classes
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP      = 4'd0;
  localparam op_t OP_ABS32    = 4'd1;
  localparam op_t OP_MOVW     = 4'd2;
  localparam op_t OP_MOVT     = 4'd3;
  localparam op_t OP_ARM_BR   = 4'd4;
  localparam op_t OP_THM_CALL = 4'd5;
  localparam op_t OP_THM_JUMP = 4'd6;
  localparam op_t OP_THM_MOVW = 4'd7;
  localparam op_t OP_THM_MOVT = 4'd8;
  localparam op_t OP_PREL31   = 4'd9;
  localparam op_t OP_ERR      = 4'd10;

  // decode stage -> sum stage
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [31:0] base;
    logic [31:0] addend;
    logic [31:0] word;
    logic        thumb_target;
  } dec_t;

  // sum stage -> pack stage
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [31:0] value;
    logic [31:0] word;
    logic        thumb_target;
  } sum_t;

endpackage

@@ design/rlp_decode.sv @@
// Stage 1: classifies the relocation type, extracts the addend, forms S or S - P.
// Depends on rlp_pkg.
module rlp_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     kind,
  input  logic [31:0]    symbol_value,
  input  logic [31:0]    place_address,
  input  logic [31:0]    original_word,
  output rlp_pkg::dec_t  dec
);
  import rlp_pkg::*;

  op_t         op_next;
  logic [31:0] base_next;
  logic [31:0] addend_next;
  logic [15:0] arm_imm;
  logic [15:0] thm_imm;
  logic        sb;
  logic        i1;
  logic        i2;
  logic [24:0] thm_off;
  logic [31:0] s_minus_p;

  assign arm_imm   = {original_word[19:16], original_word[11:0]};
  assign thm_imm   = {original_word[3:0], original_word[10], original_word[30:28],
                      original_word[23:16]};
  assign sb        = original_word[10];
  assign i1        = ~(original_word[29] ^ sb);
  assign i2        = ~(original_word[27] ^ sb);
  assign thm_off   = {sb, i1, i2, original_word[9:0], original_word[26:16], 1'b0};
  assign s_minus_p = symbol_value - place_address;

  always_comb begin
    op_next     = OP_ERR;
    base_next   = symbol_value;
    addend_next = original_word;
    case (kind)
      R_NONE, R_V4BX: begin
        op_next = OP_NOP;
      end
      R_ABS32: begin
        op_next = OP_ABS32;
      end
      R_MOVW, R_MOVT: begin
        op_next     = (kind == R_MOVW) ? OP_MOVW : OP_MOVT;
        addend_next = {{16{arm_imm[15]}}, arm_imm};
      end
      R_PC24, R_PLT32, R_CALL, R_JUMP24: begin
        op_next     = OP_ARM_BR;
        base_next   = s_minus_p;
        addend_next = {{6{original_word[23]}}, original_word[23:0], 2'b00};
      end
      R_THM_CALL, R_THM_JUMP24: begin
        op_next     = (kind == R_THM_CALL) ? OP_THM_CALL : OP_THM_JUMP;
        base_next   = s_minus_p;
        addend_next = {{7{sb}}, thm_off};
      end
      R_THM_MOVW, R_THM_MOVT: begin
        op_next     = (kind == R_THM_MOVW) ? OP_THM_MOVW : OP_THM_MOVT;
        addend_next = {{16{thm_imm[15]}}, thm_imm};
      end
      R_PREL31: begin
        op_next     = OP_PREL31;
        base_next   = s_minus_p;
        addend_next = {original_word[30], original_word[30:0]};
      end
      default: begin
        op_next = OP_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else begin
      dec.valid <= in_valid;
    end
    dec.op           <= op_next;
    dec.base         <= base_next;
    dec.addend       <= addend_next;
    dec.word         <= original_word;
    dec.thumb_target <= symbol_value[0];
  end

endmodule

@@ design/rlp_sum.sv @@
// Stage 2: adds the addend to S or S - P.
// Depends on rlp_pkg.
module rlp_sum (
  input  logic           clk,
  input  logic           rst,
  input  rlp_pkg::dec_t  dec,
  output rlp_pkg::sum_t  sum
);
  import rlp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum.valid <= 1'b0;
    end else begin
      sum.valid <= dec.valid;
    end
    sum.op           <= dec.op;
    sum.value        <= dec.base + dec.addend;
    sum.word         <= dec.word;
    sum.thumb_target <= dec.thumb_target;
  end

endmodule

@@ design/rlp_pack.sv @@
// Stage 3: BLX rounding and insertion of the value into the instruction fields.
// Depends on rlp_pkg.
module rlp_pack (
  input  logic           clk,
  input  logic           rst,
  input  rlp_pkg::sum_t  sum,
  output logic           done,
  output logic [31:0]    patched_word,
  output logic           status
);
  import rlp_pkg::*;

  logic        to_blx;
  logic [31:0] br_v;
  logic [31:0] mov_v;
  logic [15:0] hi;
  logic [15:0] lo;
  logic [15:0] lo_keep;
  logic [31:0] result_next;

  assign hi      = sum.word[15:0];
  assign lo      = sum.word[31:16];
  assign to_blx  = (sum.op == OP_THM_CALL) && !sum.thumb_target;
  assign br_v    = to_blx ? ((sum.value + 32'd2) & 32'hfffffffc) : sum.value;
  assign lo_keep = to_blx ? (lo & 16'hefff) : lo;
  assign mov_v   = (sum.op == OP_MOVT || sum.op == OP_THM_MOVT) ?
                   {16'h0000, sum.value[31:16]} : sum.value;

  always_comb begin
    case (sum.op)
      OP_ABS32: begin
        result_next = sum.value;
      end
      OP_MOVW, OP_MOVT: begin
        result_next = (sum.word & 32'hfff0f000) | {12'h000, mov_v[15:12], 4'h0, mov_v[11:0]};
      end
      OP_ARM_BR: begin
        result_next = {sum.word[31:24], sum.value[25:2]};
      end
      OP_THM_CALL, OP_THM_JUMP: begin
        result_next = {lo_keep[15:14], ~(br_v[23] ^ br_v[24]), lo_keep[12],
                       ~(br_v[22] ^ br_v[24]), br_v[11:1],
                       hi[15:11], br_v[24], br_v[21:12]};
      end
      OP_THM_MOVW, OP_THM_MOVT: begin
        result_next = {lo[15], mov_v[10:8], lo[11:8], mov_v[7:0],
                       hi[15:11], mov_v[11], hi[9:4], mov_v[15:12]};
      end
      OP_PREL31: begin
        result_next = {sum.word[31], sum.value[30:0]};
      end
      default: begin
        result_next = sum.word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sum.valid;
    end
    patched_word <= result_next;
    status       <= (sum.op == OP_ERR);
  end

endmodule

@@ design/arm_elf_relocation_patcher.sv @@
// ARM ELF REL relocation patcher, top level: three-stage pipeline.
// Depends on rlp_pkg, rlp_decode, rlp_sum, rlp_pack.
//
//   channel   strobe  ports                                             dir
//   request   start   kind, symbol_value, place_address, original_word  in
//   result    done    patched_word, status                              out
//
// One request per cycle, every cycle; busy is always low.
// done follows start through decode and S - P, addend sum,
// BLX rounding and field packing, each ending in a register.
// The receiver cannot stall; each result shows for exactly one cycle.
// Synchronous reset clears the stage valid bits only.
module arm_elf_relocation_patcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  kind,
  input  logic [31:0] symbol_value,
  input  logic [31:0] place_address,
  input  logic [31:0] original_word,
  output logic        done,
  output logic [31:0] patched_word,
  output logic        status
);
  import rlp_pkg::*;

  dec_t dec;
  sum_t sum;

  assign busy = 1'b0;

  rlp_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .kind          (kind),
    .symbol_value  (symbol_value),
    .place_address (place_address),
    .original_word (original_word),
    .dec           (dec)
  );

  rlp_sum u_sum (
    .clk (clk),
    .rst (rst),
    .dec (dec),
    .sum (sum)
  );

  rlp_pack u_pack (
    .clk          (clk),
    .rst          (rst),
    .sum          (sum),
    .done         (done),
    .patched_word (patched_word),
    .status       (status)
  );

endmodule
